>>> rtl/cdo_pkg.sv
package cdo_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int FRAC_BITS       = 16;
    localparam int SINE_FRAC       = 15;
    localparam int TABLE_LEN       = 1 << SINE_TABLE_BITS;
    localparam int QUARTER_LEN     = TABLE_LEN / 4;
    localparam int QADDR_W         = SINE_TABLE_BITS - 1;
    localparam int SINE_W          = 16;
    localparam int SINE_MAG_W      = 15;

    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint ONE_Q30    = 64'sd1073741824;
    localparam longint SINE_MAX   = 64'sd32767;

    localparam int ANGLE_W    = 16;
    localparam int WORD_W     = 32;
    localparam int GAIN_W     = 30;
    localparam int TPOS_W     = 26;
    localparam int TNEG_W     = 27;
    localparam int COEF_W     = 31;
    localparam int LIM_W      = 15;
    localparam int TORQUE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DIFF_W  = WORD_W + 1;

    localparam int HOLD_SHIFT = 2 * FRAC_BITS;
    localparam logic signed [PROD_W-1:0] HOLD_ROUND = PROD_W'((64'sd1 <<< HOLD_SHIFT) - 64'sd1);

    // floor division by the trapezoid step: shift by 4, then reciprocal of 125
    localparam int     DIV_STEP      = 2000;
    localparam int     DIV_PRE_SHIFT = 4;
    localparam int     DIV_ODD       = DIV_STEP >> DIV_PRE_SHIFT;
    localparam int     DIV_BIAS_EXP  = 22;
    localparam int     DIV_BIAS      = 1 << DIV_BIAS_EXP;
    localparam int     DIV_OFFSET    = DIV_ODD * DIV_BIAS;
    localparam int     DIV_N_W       = 30;
    localparam int     DIV_SHIFT     = 36;
    localparam longint DIV_MULT      = ((64'sd1 <<< DIV_SHIFT) + DIV_ODD - 1) / DIV_ODD;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-64'sd2147483648);

    localparam logic [GAIN_W-1:0]        GAIN_RESET   = 30'd65536000;
    localparam logic [TPOS_W-1:0]        TPOS_RESET   = 26'd294912;
    localparam logic signed [TNEG_W-1:0] TNEG_RESET   = -27'sd347341;
    localparam logic [COEF_W-1:0]        TSCALE_RESET = 31'd65536;
    localparam logic [LIM_W-1:0]         LIM_RESET    = 15'd32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_K,
        CFG_THRESH_POS,
        CFG_THRESH_NEG,
        CFG_GRAVITY_COEFF,
        CFG_ENERGY_COEFF,
        CFG_TORQUE_SCALE,
        CFG_HOLD_SCALE,
        CFG_CURRENT_LIMIT
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TORQUE,
        S_GRAV,
        S_VEL,
        S_HOLD,
        S_ENERGY,
        S_SUM,
        S_DIVN,
        S_DIV,
        S_ACC,
        S_DIFF,
        S_GAIN,
        S_FIN,
        S_TOGGLE
    } t_state;

    typedef logic [SINE_MAG_W-1:0] t_qsine [0:QUARTER_LEN];

    // quarter-wave sine, round(sin * 32767), series evaluated in q2.30
    function automatic t_qsine qsine_build();
        t_qsine tab;
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint val;
        for (int j = 0; j <= QUARTER_LEN; j++) begin
            x    = longint'(j) * TWO_PI_Q30 / TABLE_LEN;
            x2   = x * x / ONE_Q30;
            term = x;
            sum  = x;
            term = -(term * x2 / ONE_Q30) / 64'sd6;
            sum  = sum + term;
            term = -(term * x2 / ONE_Q30) / 64'sd20;
            sum  = sum + term;
            term = -(term * x2 / ONE_Q30) / 64'sd42;
            sum  = sum + term;
            term = -(term * x2 / ONE_Q30) / 64'sd72;
            sum  = sum + term;
            term = -(term * x2 / ONE_Q30) / 64'sd110;
            sum  = sum + term;
            term = -(term * x2 / ONE_Q30) / 64'sd156;
            sum  = sum + term;
            if (sum < 0) begin
                sum = 0;
            end
            val = (sum * SINE_MAX + ONE_Q30 / 2) / ONE_Q30;
            if (val > SINE_MAX) begin
                val = SINE_MAX;
            end
            tab[j] = SINE_MAG_W'(val);
        end
        return tab;
    endfunction

    localparam t_qsine QSINE = qsine_build();

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[WORD_W-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[WORD_W-1:0];
        end else begin
            return v[WORD_W-1:0];
        end
    endfunction

endpackage

>>> rtl/cdo_if.sv
interface cdo_in_if import cdo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [ANGLE_W-1:0]       angle;
    logic signed [WORD_W-1:0] velocity;
    logic signed [WORD_W-1:0] motor_current;

    modport source (output valid, output op, output angle, output velocity,
                    output motor_current, input ready);
    modport sink   (input valid, input op, input angle, input velocity,
                    input motor_current, output ready);
endinterface

interface cdo_out_if import cdo_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [WORD_W-1:0]   residual;
    logic                       collision_flag;
    logic                       hold_active;
    logic signed [TORQUE_W-1:0] hold_torque;

    modport source (output valid, output residual, output collision_flag,
                    output hold_active, output hold_torque, input ready);
    modport sink   (input valid, input residual, input collision_flag,
                    input hold_active, input hold_torque, output ready);
endinterface

interface cdo_cfg_if import cdo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/collision_disturbance_observer_unit.sv
// single-axis collision observer, one sample beat per control tick
// i_in: sample or pause/resume beat (op = 1 toggles hold mode, clears the latch)
// o_out: residual, collision latch, hold mode and hold torque, one beat per input beat
// i_cfg: register writes by index, always ready, to be used while the block is idle
// a sample runs through the states torque, grav, vel, hold, energy, sum, divn, div,
// acc, diff, gain and fin before its result is registered, a toggle through the
// toggle state only; the single shared 34 x 32 multiplier carries seven products
// in turn under the sequencer, one per cycle with a register after it
// i_in.ready is high only while the sequencer is idle, so one beat is in work at a time
// the result sits in an output register; if the receiver stalls, the next beat can
// still be taken and worked, and it waits in its last state until the register frees
// reset (synchronous, active low) restores the default registers, clears the
// integrator, residual, latch and hold mode and drops the output beat
// the sine table is a constant quarter-wave table, no fill pass is needed
module collision_disturbance_observer_unit import cdo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdo_in_if.sink      i_in,
    cdo_out_if.source   o_out,
    cdo_cfg_if.sink     i_cfg
);

    t_state r_state;
    t_state n_state;

    logic [GAIN_W-1:0]        r_gain;
    logic [TPOS_W-1:0]        r_tpos;
    logic signed [TNEG_W-1:0] r_tneg;
    logic [COEF_W-1:0]        r_gcoef;
    logic [COEF_W-1:0]        r_ecoef;
    logic [COEF_W-1:0]        r_tscale;
    logic [COEF_W-1:0]        r_hscale;
    logic [LIM_W-1:0]         r_lim;

    logic signed [WORD_W-1:0] r_integral;
    logic signed [WORD_W-1:0] r_prev_deriv;
    logic signed [WORD_W-1:0] r_residual;
    logic signed [WORD_W-1:0] r_prev_gt;
    logic                     r_latch;
    logic                     r_hold;

    logic                       r_out_valid;
    logic signed [WORD_W-1:0]   r_out_res;
    logic                       r_out_coll;
    logic                       r_out_hold;
    logic signed [TORQUE_W-1:0] r_out_torque;

    logic [ANGLE_W-1:0]         r_angle;
    logic signed [WORD_W-1:0]   r_vel;
    logic signed [WORD_W-1:0]   r_cur;
    logic signed [SINE_W-1:0]   r_sin;
    logic signed [WORD_W-1:0]   r_torque;
    logic signed [WORD_W-1:0]   r_g;
    logic signed [WORD_W-1:0]   r_v2;
    logic signed [TORQUE_W-1:0] r_cmd;
    logic signed [WORD_W-1:0]   r_p;
    logic signed [WORD_W-1:0]   r_yp;
    logic [DIV_N_W-1:0]         r_divn;
    logic signed [WORD_W-1:0]   r_y;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [PROD_W-1:0]   r_prod;

    logic                        accept;
    logic                        out_free;
    logic                        fin_go;
    logic                        tog_go;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;

    logic [SINE_TABLE_BITS-1:0]  sin_idx;
    logic [QADDR_W-1:0]          sin_addr;
    logic [SINE_MAG_W-1:0]       sin_mag;
    logic signed [SINE_W-1:0]    sin_val;

    logic signed [PROD_W-1:0]    hold_t;
    logic signed [PROD_W-1:0]    hold_q;
    logic signed [PROD_W-1:0]    lim_w;
    logic signed [TORQUE_W-1:0]  hold_cmd;

    logic signed [DIFF_W-1:0]    div_sum;
    logic signed [DIFF_W-1:0]    div_pre;
    logic signed [MUL_A_W-1:0]   div_n;
    logic signed [PROD_W-1:0]    div_q;

    logic signed [WORD_W-1:0]    res_next;
    logic                        det;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign fin_go   = (r_state == S_FIN) && out_free;
    assign tog_go   = (r_state == S_TOGGLE) && out_free;

    assign i_in.ready           = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_out_valid;
    assign o_out.residual       = r_out_res;
    assign o_out.collision_flag = r_out_coll;
    assign o_out.hold_active    = r_out_hold;
    assign o_out.hold_torque    = r_out_torque;

    // quarter-wave lookup
    assign sin_idx  = r_angle[ANGLE_W-1 -: SINE_TABLE_BITS];
    assign sin_addr = sin_idx[SINE_TABLE_BITS-2]
                    ? QADDR_W'(QUARTER_LEN) - {1'b0, sin_idx[SINE_TABLE_BITS-3:0]}
                    : {1'b0, sin_idx[SINE_TABLE_BITS-3:0]};
    assign sin_mag  = QSINE[sin_addr];
    assign sin_val  = sin_idx[SINE_TABLE_BITS-1] ? -$signed({1'b0, sin_mag})
                                                 : $signed({1'b0, sin_mag});

    // hold torque, truncated toward zero and clamped
    assign hold_t = r_prod[PROD_W-1] ? r_prod + HOLD_ROUND : r_prod;
    assign hold_q = hold_t >>> HOLD_SHIFT;
    assign lim_w  = PROD_W'($signed({1'b0, r_lim}));

    always_comb begin
        if (hold_q > lim_w) begin
            hold_cmd = TORQUE_W'(lim_w);
        end else if (hold_q < -lim_w) begin
            hold_cmd = TORQUE_W'(-lim_w);
        end else begin
            hold_cmd = TORQUE_W'(hold_q);
        end
    end

    assign div_sum = DIFF_W'(r_yp) + DIFF_W'(r_prev_deriv);
    assign div_pre = div_sum >>> DIV_PRE_SHIFT;
    assign div_n   = MUL_A_W'(div_pre) + MUL_A_W'(DIV_OFFSET);
    assign div_q   = (r_prod >>> DIV_SHIFT) - PROD_W'(DIV_BIAS);

    assign res_next = sat32(r_prod >>> FRAC_BITS);
    assign det      = ((DIFF_W'(res_next) > $signed({7'b0, r_tpos}))
                    || (DIFF_W'(res_next) < DIFF_W'(r_tneg))) && !r_latch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_in.op ? S_TOGGLE : S_TORQUE;
                end
            end
            S_TORQUE: begin
                mul_a   = MUL_A_W'(r_cur);
                mul_b   = $signed({1'b0, r_tscale});
                n_state = S_GRAV;
            end
            S_GRAV: begin
                mul_a   = MUL_A_W'($signed({1'b0, r_gcoef}));
                mul_b   = MUL_B_W'(r_sin);
                n_state = S_VEL;
            end
            S_VEL: begin
                mul_a   = MUL_A_W'(r_vel);
                mul_b   = r_vel;
                n_state = S_HOLD;
            end
            S_HOLD: begin
                mul_a   = MUL_A_W'(r_prev_gt);
                mul_b   = $signed({1'b0, r_hscale});
                n_state = S_ENERGY;
            end
            S_ENERGY: begin
                mul_a   = MUL_A_W'($signed({1'b0, r_ecoef}));
                mul_b   = r_v2;
                n_state = S_SUM;
            end
            S_SUM:  n_state = S_DIVN;
            S_DIVN: n_state = S_DIV;
            S_DIV: begin
                mul_a   = $signed({4'b0, r_divn});
                mul_b   = MUL_B_W'(DIV_MULT);
                n_state = S_ACC;
            end
            S_ACC:  n_state = S_DIFF;
            S_DIFF: n_state = S_GAIN;
            S_GAIN: begin
                mul_a   = MUL_A_W'(r_diff);
                mul_b   = $signed({2'b0, r_gain});
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_TOGGLE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration, observer state and output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= GAIN_RESET;
            r_tpos       <= TPOS_RESET;
            r_tneg       <= TNEG_RESET;
            r_gcoef      <= '0;
            r_ecoef      <= '0;
            r_tscale     <= TSCALE_RESET;
            r_hscale     <= '0;
            r_lim        <= LIM_RESET;
            r_integral   <= '0;
            r_prev_deriv <= '0;
            r_residual   <= '0;
            r_prev_gt    <= '0;
            r_latch      <= 1'b0;
            r_hold       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_GAIN_K:        r_gain   <= i_cfg.data[GAIN_W-1:0];
                    CFG_THRESH_POS:    r_tpos   <= i_cfg.data[TPOS_W-1:0];
                    CFG_THRESH_NEG:    r_tneg   <= $signed(i_cfg.data[TNEG_W-1:0]);
                    CFG_GRAVITY_COEFF: r_gcoef  <= i_cfg.data[COEF_W-1:0];
                    CFG_ENERGY_COEFF:  r_ecoef  <= i_cfg.data[COEF_W-1:0];
                    CFG_TORQUE_SCALE:  r_tscale <= i_cfg.data[COEF_W-1:0];
                    CFG_HOLD_SCALE:    r_hscale <= i_cfg.data[COEF_W-1:0];
                    CFG_CURRENT_LIMIT: r_lim    <= i_cfg.data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (o_out.ready && !fin_go && !tog_go) begin
                r_out_valid <= 1'b0;
            end
            if (fin_go) begin
                r_integral   <= r_y;
                r_prev_deriv <= r_yp;
                r_residual   <= res_next;
                r_prev_gt    <= -r_g;
                r_latch      <= r_latch | det;
                r_hold       <= r_hold ^ det;
                r_out_valid  <= 1'b1;
                r_out_res    <= res_next;
                r_out_coll   <= r_latch | det;
                r_out_hold   <= r_hold ^ det;
                r_out_torque <= r_cmd;
            end
            if (tog_go) begin
                r_hold       <= !r_hold;
                r_latch      <= 1'b0;
                r_out_valid  <= 1'b1;
                r_out_res    <= r_residual;
                r_out_coll   <= 1'b0;
                r_out_hold   <= !r_hold;
                r_out_torque <= '0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (r_state != S_FIN) begin
            r_prod <= mul_a * mul_b;
        end
        if (accept) begin
            r_angle <= i_in.angle;
            r_vel   <= i_in.velocity;
            r_cur   <= i_in.motor_current;
        end
        unique case (r_state)
            S_TORQUE: r_sin    <= sin_val;
            S_GRAV:   r_torque <= sat32(r_prod >>> FRAC_BITS);
            S_VEL:    r_g      <= sat32(r_prod >>> SINE_FRAC);
            S_HOLD:   r_v2     <= sat32(r_prod >>> FRAC_BITS);
            S_ENERGY: r_cmd    <= r_hold ? hold_cmd : '0;
            S_SUM: begin
                r_p  <= sat32(r_prod >>> FRAC_BITS);
                r_yp <= sat32(PROD_W'(r_torque) + (PROD_W'(r_g) <<< 1)
                              - PROD_W'(r_residual));
            end
            S_DIVN:   r_divn   <= div_n[DIV_N_W-1:0];
            S_ACC:    r_y      <= sat32(PROD_W'(r_integral) + div_q);
            S_DIFF:   r_diff   <= DIFF_W'(r_y) - DIFF_W'(r_p);
            default: ;
        endcase
    end

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("input taken while a beat is in work");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_FIN || r_state == S_TOGGLE))
        else $error("output beat raised outside the final states");

    a_detect_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && det) |=> (r_latch && (r_hold != $past(r_hold))))
        else $error("collision did not latch and toggle hold mode");

    a_toggle_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tog_go |=> (!r_latch && o_out.valid && !o_out.collision_flag))
        else $error("pause toggle did not clear the latch");

endmodule
